// ===== hw/rtl/acek_pkg.sv =====
// shared types, constants and aes round functions for the ctr keystream block
`timescale 1ns / 1ps

package acek_pkg;

  localparam int BLK_BITS   = 128;
  localparam int KEY_BITS   = 256;
  localparam int ROUNDS     = 14;
  localparam int KSQ_DEPTH  = 2;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  typedef logic [BLK_BITS-1:0] blk_t;
  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [2:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_CTR_HI = 3'd4,
    CFG_CTR_LO = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // generator flush request: restart reloads the counter from config
  typedef struct packed {
    logic req;
    logic restart;
  } flush_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX_TBL[(11'd2047 - {a, 3'b000}) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // subbytes, shiftrows, mixcolumns (skipped in the final round), add round key
  function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    blk_t r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = sbox(s[127 - 8*(4*((c+i)%4)+i) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      if (last) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                             xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
    end
    return r ^ rk;
  endfunction

  // next four schedule words from the previous eight
  function automatic blk_t key_next(input blk_t ka, input blk_t kb, input logic [7:0] rcon,
                                    input logic rot);
    logic [31:0] t, n0, n1, n2, n3;
    t = kb[31:0];
    if (rot) begin
      t = {sbox(t[23:16]) ^ rcon, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
    end else begin
      t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    end
    n0 = ka[127:96] ^ t;
    n1 = ka[95:64] ^ n0;
    n2 = ka[63:32] ^ n1;
    n3 = ka[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// ===== hw/rtl/acek_core.sv =====
// iterative aes-256 encryptor, one round per cycle, key schedule on the fly
`timescale 1ns / 1ps

module acek_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cancel,
  input  acek_pkg::key_t  key,
  input  acek_pkg::blk_t  blk_in,
  input  logic            ack,
  output logic            busy,
  output logic            res_valid,
  output acek_pkg::blk_t  res
);

  localparam logic [3:0] LAST_RND = 4'(acek_pkg::ROUNDS);

  acek_pkg::blk_t state, ka, kb;
  logic [3:0]     rnd;
  logic [7:0]     rcon;

  always_ff @(posedge clk) begin
    if (rst || cancel) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else if (start) begin
      state     <= blk_in ^ key[255:128];
      ka        <= key[255:128];
      kb        <= key[127:0];
      rnd       <= 4'd1;
      rcon      <= 8'h01;
      busy      <= 1'b1;
      res_valid <= 1'b0;
    end else if (busy) begin
      state <= acek_pkg::aes_round(state, kb, rnd == LAST_RND);
      ka    <= kb;
      kb    <= acek_pkg::key_next(ka, kb, rcon, rnd[0]);
      if (rnd[0]) begin
        rcon <= acek_pkg::xtime(rcon);
      end
      rnd <= rnd + 4'd1;
      if (rnd == LAST_RND) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
    end else if (ack) begin
      res_valid <= 1'b0;
    end
  end

  assign res = state;

endmodule

// ===== hw/rtl/acek_ksq.sv =====
// short queue of keystream blocks between generator and byte front end
`timescale 1ns / 1ps

module acek_ksq #(
  parameter int DEPTH = acek_pkg::KSQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           flush,
  input  logic           push,
  input  acek_pkg::blk_t push_data,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output acek_pkg::blk_t q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  acek_pkg::blk_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign q_valid = count != '0;
  assign q_full  = count == CNT_FULL;
  assign q_data  = entries[rd_ptr];

endmodule

// ===== hw/rtl/acek_gen.sv =====
// back end: counter tracking and keystream block generation ahead of use
`timescale 1ns / 1ps

module acek_gen (
  input  logic             clk,
  input  logic             rst,
  input  acek_pkg::key_t   key,
  input  acek_pkg::blk_t   init_ctr,
  input  acek_pkg::flush_t flush,
  input  logic             pop,
  input  logic             q_full,
  output logic             push,
  output acek_pkg::blk_t   push_data
);

  acek_pkg::blk_t gen_ctr, cons_ctr;
  logic           core_busy, res_valid, start;

  assign push  = res_valid && (!q_full || pop) && !flush.req;
  assign start = !core_busy && (!res_valid || push) && !flush.req;

  acek_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cancel    (flush.req),
    .key       (key),
    .blk_in    (gen_ctr),
    .ack       (push),
    .busy      (core_busy),
    .res_valid (res_valid),
    .res       (push_data)
  );

  // gen_ctr: next block to encrypt; cons_ctr: block the front end takes next
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_ctr  <= '0;
      cons_ctr <= '0;
    end else if (flush.req) begin
      if (flush.restart) begin
        gen_ctr  <= init_ctr;
        cons_ctr <= init_ctr;
      end else begin
        gen_ctr <= cons_ctr;
      end
    end else begin
      if (start) begin
        gen_ctr <= gen_ctr + 1'b1;
      end
      if (pop) begin
        cons_ctr <= cons_ctr + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/acek_front.sv =====
// front end: byte accept, offset tracking, keystream xor and output register
`timescale 1ns / 1ps

module acek_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  acek_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acek_pkg::out_beat_t out_data,
  input  logic                q_valid,
  input  acek_pkg::blk_t      q_data,
  output logic                pop,
  output logic                restart_req
);

  logic [3:0]     offset, eff_off;
  acek_pkg::blk_t ks, blk;
  logic           armed, need, can_out, accept;
  logic [7:0]     ksb;

  always_comb begin
    eff_off     = in_data.action ? 4'd0 : offset;
    need        = eff_off == 4'd0;
    can_out     = !out_valid || out_ready;
    in_ready    = can_out && (!need || q_valid) && (!in_data.action || armed);
    restart_req = in_valid && in_data.action && !armed;
    accept      = in_valid && in_ready;
    pop         = accept && need;
    blk         = need ? q_data : ks;
    ksb         = blk[(7'd127 - {eff_off, 3'b000}) -: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= 4'd0;
      armed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (restart_req) begin
        armed <= 1'b1;
      end
      if (accept) begin
        armed             <= 1'b0;
        offset            <= eff_off + 4'd1;
        out_data.out_byte <= in_data.data_byte ^ ksb;
        out_data.out_last <= in_data.in_last;
        out_valid         <= 1'b1;
        if (pop) begin
          ks <= q_data;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/aes_ctr_keystream_xor.sv =====
// top level of the aes-256 counter mode byte stream transformer
`timescale 1ns / 1ps

// usage
// - input channel (in_valid / in_ready / in_data) takes one byte per beat with an
//   action bit (1 = reload counter from config and start a fresh block) and a last mark
// - output channel (out_valid / out_ready / out_data) gives the transformed byte and
//   the copied last mark, one beat per input beat, in order
// - apb port holds four 64-bit key words and the starting counter (hi, lo) at
//   byte addresses 8*i; write only while the stream is idle
// timing and throughput
// - the output beat is registered; one byte per cycle sustained unless stalled
// - the iterative aes core (one round per cycle) yields keystream blocks that are
//   kept ahead of the byte stream in a two-block queue
// - a restart beat flushes the queue and waits for its block to be encrypted;
//   a key write also flushes and regenerates from the current counter
// reset
// - counter and offset clear; the core starts on the first block once reset is released
// stalls
// - a stalled receiver holds the output register and in_ready drops at once;
//   the generator idles once the queue is full

module aes_ctr_keystream_xor #(
  parameter int KSQ_DEPTH = acek_pkg::KSQ_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  acek_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output acek_pkg::out_beat_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [acek_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [acek_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [acek_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // configuration registers
  logic [63:0]        key0, key1, key2, key3, ctr_hi, ctr_lo;
  acek_pkg::cfg_idx_t cfg_idx;
  logic               cfg_wr, key_wr;

  // front to back plumbing
  acek_pkg::flush_t   flush;
  acek_pkg::blk_t     push_data, q_data;
  logic               push, pop, q_valid, q_full, restart_req;

  assign pready  = 1'b1;
  assign cfg_idx = acek_pkg::cfg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    key_wr = cfg_wr && (cfg_idx inside {acek_pkg::CFG_KEY0, acek_pkg::CFG_KEY1,
                                        acek_pkg::CFG_KEY2, acek_pkg::CFG_KEY3});
    case (cfg_idx)
      acek_pkg::CFG_KEY0:   prdata = key0;
      acek_pkg::CFG_KEY1:   prdata = key1;
      acek_pkg::CFG_KEY2:   prdata = key2;
      acek_pkg::CFG_KEY3:   prdata = key3;
      acek_pkg::CFG_CTR_HI: prdata = ctr_hi;
      acek_pkg::CFG_CTR_LO: prdata = ctr_lo;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key0   <= '0;
      key1   <= '0;
      key2   <= '0;
      key3   <= '0;
      ctr_hi <= '0;
      ctr_lo <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        acek_pkg::CFG_KEY0:   key0   <= pwdata;
        acek_pkg::CFG_KEY1:   key1   <= pwdata;
        acek_pkg::CFG_KEY2:   key2   <= pwdata;
        acek_pkg::CFG_KEY3:   key3   <= pwdata;
        acek_pkg::CFG_CTR_HI: ctr_hi <= pwdata;
        acek_pkg::CFG_CTR_LO: ctr_lo <= pwdata;
        default: ;
      endcase
    end
  end

  // restart reloads the counter; a new key discards blocks made under the old one
  assign flush.req     = restart_req || key_wr;
  assign flush.restart = restart_req;

  acek_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop),
    .restart_req (restart_req)
  );

  acek_ksq #(
    .DEPTH (KSQ_DEPTH)
  ) u_ksq (
    .clk       (clk),
    .rst       (rst),
    .flush     (flush.req),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  acek_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .key       ({key0, key1, key2, key3}),
    .init_ctr  ({ctr_hi, ctr_lo}),
    .flush     (flush),
    .pop       (pop),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

`ifndef SYNTHESIS
  // a block is only taken when one is queued
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("keystream pop from empty queue");

  // a flush leaves no stale block behind
  a_flush_empty: assert property (@(posedge clk) disable iff (rst) flush.req |=> !q_valid)
    else $error("queue not empty after flush");

  // a push into a full queue must coincide with a pop
  a_push_room: assert property (@(posedge clk) disable iff (rst) (push && q_full) |-> pop)
    else $error("keystream push into full queue");
`endif

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the aes-256 counter mode byte stream transformer
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // stream side
  logic                in_valid = 1'b0;
  logic                in_ready;
  acek_pkg::in_beat_t  in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  acek_pkg::out_beat_t out_data;

  // register port
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [acek_pkg::CFG_ADDR_W-1:0] paddr   = '0;
  logic [acek_pkg::CFG_DATA_W-1:0] pwdata  = '0;
  logic [acek_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  aes_ctr_keystream_xor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // beats waiting to be offered, and the bytes the cipher stream should give back
  acek_pkg::in_beat_t  send_q[$];
  acek_pkg::out_beat_t cipher_q[$];

  // mirror of the block's register file and stream state
  logic [255:0] key_m;
  logic [127:0] init_ctr_m;
  logic [127:0] ctr_m;
  logic [127:0] ks_m;
  logic [3:0]   off_m;
  logic [7:0]   sub_tbl [256];

  int  errs = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  blocks_made = 0;
  int  restarts = 0;
  int  cycles = 0;
  int  hold_cnt = 0;
  bit  held_once = 1'b0;
  bit  quiet = 1'b0;   // no random idling on either side while set

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // aes-256, written out from the field arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return r;
  endfunction

  // multiplicative inverse (a^254) followed by the affine map
  function automatic logic [7:0] sub_calc(input logic [7:0] a);
    logic [7:0] inv, p;
    int e;
    inv = 8'h01;
    p = a;
    e = 254;
    while (e != 0) begin
      if (e & 1) inv = gmul(inv, p);
      p = gmul(p, p);
      e = e >> 1;
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [127:0] encrypt256(input logic [255:0] k, input logic [127:0] pt);
    logic [7:0] rk [240];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, rcon, a0, a1, a2, a3;
    logic [127:0] ct;
    rcon = 8'h01;
    for (int i = 0; i < 32; i++) rk[i] = k[255-8*i -: 8];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if (i % 8 == 0) begin
        f = w[0];
        w[0] = sub_tbl[w[1]] ^ rcon;
        w[1] = sub_tbl[w[2]];
        w[2] = sub_tbl[w[3]];
        w[3] = sub_tbl[f];
        rcon = gmul(rcon, 8'h02);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) w[j] = sub_tbl[w[j]];
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-8)+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 14; r++) begin
      // substitute and shift rows
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[4*c+i] = sub_tbl[s[4*((c+i)%4)+i]];
      // column mix, left out of the final round
      if (r != 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          t[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
          t[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
          t[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
    return ct;
  endfunction

  // one byte through the counter mode stream
  function automatic acek_pkg::out_beat_t ctr_xor_byte(input acek_pkg::in_beat_t b);
    acek_pkg::out_beat_t o;
    if (b.action) begin
      ctr_m = init_ctr_m;
      off_m = '0;
      restarts++;
    end
    // fresh keystream block at the start of each 16-byte block
    if (off_m == 4'd0) begin
      ks_m = encrypt256(key_m, ctr_m);
      ctr_m = ctr_m + 128'd1;   // wraps from all ones to zero
      blocks_made++;
    end
    o.out_byte = b.data_byte ^ ks_m[127-8*off_m -: 8];
    o.out_last = b.in_last;
    off_m = off_m + 4'd1;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers queued beats, holds each until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= send_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off once the stream is well under way
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!held_once && beats_in >= 650) begin
      held_once <= 1'b1;
      hold_cnt  <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: predict on each accepted input beat, check each accepted output beat
  always @(posedge clk) begin
    acek_pkg::out_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        cipher_q.push_back(ctr_xor_byte(in_data));
        beats_in <= beats_in + 1;
      end
      if (out_valid && out_ready) begin
        beats_out <= beats_out + 1;
        if (cipher_q.size() == 0) begin
          $error("unexpected output beat: out_byte %02h out_last %0b",
                 out_data.out_byte, out_data.out_last);
          errs++;
        end else begin
          want = cipher_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            errs++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, out_data.out_last);
            errs++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, cipher_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // apb write: setup cycle then access cycle, mirror updated as the register takes it
  task automatic reg_write(input acek_pkg::cfg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= acek_pkg::CFG_ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      acek_pkg::CFG_KEY0:   key_m[255:192] = val;
      acek_pkg::CFG_KEY1:   key_m[191:128] = val;
      acek_pkg::CFG_KEY2:   key_m[127:64]  = val;
      acek_pkg::CFG_KEY3:   key_m[63:0]    = val;
      acek_pkg::CFG_CTR_HI: init_ctr_m[127:64] = val;
      acek_pkg::CFG_CTR_LO: init_ctr_m[63:0]   = val;
      default: ;
    endcase
  endtask

  task automatic load_key(input logic [255:0] k);
    reg_write(acek_pkg::CFG_KEY0, k[255:192]);
    reg_write(acek_pkg::CFG_KEY1, k[191:128]);
    reg_write(acek_pkg::CFG_KEY2, k[127:64]);
    reg_write(acek_pkg::CFG_KEY3, k[63:0]);
  endtask

  task automatic load_ctr(input logic [127:0] c);
    reg_write(acek_pkg::CFG_CTR_HI, c[127:64]);
    reg_write(acek_pkg::CFG_CTR_LO, c[63:0]);
  endtask

  task automatic push(input logic act, input logic [7:0] d, input logic lst);
    acek_pkg::in_beat_t b;
    b.action = act;
    b.data_byte = d;
    b.in_last = lst;
    send_q.push_back(b);
  endtask

  // messages of random length and content, mostly continuing the stream
  task automatic push_stream(input int n, input int restart_pct);
    int left;
    left = n;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 40);
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        push((i == 0) && ($urandom_range(99) < restart_pct), 8'($urandom),
             (i == len - 1) ? 1'b1 : 1'($urandom_range(9) == 0));
      left -= len;
    end
  endtask

  // idle point: everything sent and returned, then let the key generator settle
  task automatic drain();
    while (send_q.size() != 0 || in_valid || cipher_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) sub_tbl[i] = sub_calc(8'(i));
    key_m = '0;
    init_ctr_m = '0;
    ctr_m = '0;
    ks_m = '0;
    off_m = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // stream straight out of reset: zero key, zero counter, no restart
    push(1'b0, 8'h00, 1'b0);
    push(1'b0, 8'hff, 1'b0);
    for (int i = 0; i < 16; i++) push(1'b0, 8'(i * 17), i == 15);
    drain();

    // all-ones key, counter one below wrap so the second block wraps to zero
    load_key({256{1'b1}});
    load_ctr({128{1'b1}});
    push(1'b1, 8'h5a, 1'b0);
    for (int i = 0; i < 20; i++) push(1'b0, 8'($urandom), i == 19);
    // restart in the middle of a block
    push(1'b1, 8'ha5, 1'b1);
    push(1'b0, 8'h00, 1'b0);
    drain();

    // key change mid-block: current block stays, new key from the next one
    load_key(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f);
    for (int i = 0; i < 10; i++) push(1'b0, 8'hff, 1'b0);
    drain();

    // counter register written without a restart, so it must not take effect yet
    load_ctr(128'h00112233_44556677_8899aabb_ccddeeff);
    for (int i = 0; i < 12; i++) push(1'b0, 8'($urandom), 1'b1);
    drain();

    // random phases: new key and counter each time, low word often near wrap
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 2);
      load_key({rand128(), rand128()});
      if (ph == 1) load_ctr({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffd});
      else if (ph == 3) load_ctr({$urandom, $urandom, 64'hffff_ffff_ffff_fff0});
      else load_ctr(rand128());
      push(1'b1, 8'($urandom), 1'b0);
      push_stream(215, 8);
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d beats in, %0d out, %0d keystream blocks, %0d restarts",
             beats_in, beats_out, blocks_made, restarts);
    $display("key and counter extremes, mid-block key change, counter wrap, long output hold");
    if (errs == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/acek_pkg.sv
hw/rtl/acek_core.sv
hw/rtl/acek_ksq.sv
hw/rtl/acek_gen.sv
hw/rtl/acek_front.sv
hw/rtl/aes_ctr_keystream_xor.sv
verif/tb.sv
